// ===== design/mte_pkg.sv =====
package mte_pkg;

    localparam int ENC_BITS       = 13;
    localparam int ENC_RANGE      = 1 << ENC_BITS;
    localparam int HALF_ENC_RANGE = ENC_RANGE / 2;

    localparam logic [ENC_BITS-1:0] RESET_READING = ENC_BITS'(HALF_ENC_RANGE - 1);

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CONTROL_MODE   = 3'd0,
        REG_ANGLE_ABSOLUTE = 3'd1,
        REG_REVERSED       = 3'd2,
        REG_MAX_TURNS      = 3'd3,
        REG_MIN_TURNS      = 3'd4,
        REG_HALF_RATIO     = 3'd5
    } cfg_reg_t;

    localparam logic [1:0] MODE_SPEED = 2'd1;

    localparam logic OP_FEEDBACK = 1'b0;
    localparam logic OP_RESET    = 1'b1;

endpackage

// ===== design/mte_in_if.sv =====
interface mte_in_if;

    logic                            valid;
    logic                            ready;
    logic                            op;
    logic [mte_pkg::ENC_BITS-1:0]    enc_reading;
    logic signed [15:0]              rotor_speed;
    logic signed [15:0]              motor_current;
    logic [7:0]                      motor_temp;
    logic signed [31:0]              target_count;

    modport source (
        output valid, op, enc_reading, rotor_speed, motor_current, motor_temp, target_count,
        input  ready
    );

    modport sink (
        input  valid, op, enc_reading, rotor_speed, motor_current, motor_temp, target_count,
        output ready
    );

endinterface

// ===== design/mte_out_if.sv =====
interface mte_out_if;

    logic               valid;
    logic               ready;
    logic signed [31:0] angle_count;
    logic signed [15:0] turn_count;
    logic signed [15:0] speed_out;
    logic signed [15:0] current_out;
    logic [7:0]         temp_out;

    modport source (
        output valid, angle_count, turn_count, speed_out, current_out, temp_out,
        input  ready
    );

    modport sink (
        input  valid, angle_count, turn_count, speed_out, current_out, temp_out,
        output ready
    );

endinterface

// ===== design/multiturn_encoder_tracker.sv =====
// The result word of an accepted input word is registered and offered in the cycle after it is accepted.
// Throughput: one word per cycle while the result word is taken; the tracking state registers
// close the only loop, updated in a single pass per word.
// Reset (rst_n low, asynchronous): configuration to defaults, turns and offset to zero,
// last reading to 4095, last feedback to zero, no result word pending.
module multiturn_encoder_tracker (
    input  logic                              clk,
    input  logic                              rst_n,
    mte_in_if.sink                            in_ch,
    mte_out_if.source                         out_ch,
    input  logic                              cfg_wr_en,
    input  logic [mte_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mte_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int EB = mte_pkg::ENC_BITS;

    // configuration
    logic [1:0]         control_mode_reg;
    logic               angle_absolute_reg;
    logic               reversed_reg;
    logic signed [15:0] max_turns_reg;
    logic signed [15:0] min_turns_reg;
    logic [13:0]        half_ratio_reg;

    // tracking state
    logic [EB-1:0]      prev_reading_reg;
    logic signed [15:0] turns_reg;
    logic [31:0]        angle_offset_reg;
    logic signed [15:0] last_speed_reg;
    logic signed [15:0] last_current_reg;
    logic [7:0]         last_temp_reg;

    logic [EB-1:0]      prev_reading_next;
    logic signed [15:0] turns_next;
    logic [31:0]        angle_offset_next;
    logic signed [15:0] last_speed_next;
    logic signed [15:0] last_current_next;
    logic [7:0]         last_temp_next;

    // result register
    logic               out_valid_reg;
    logic signed [31:0] angle_count_reg;
    logic signed [15:0] turn_count_reg;
    logic signed [15:0] speed_out_reg;
    logic signed [15:0] current_out_reg;
    logic [7:0]         temp_out_reg;

    logic signed [31:0] angle_count_next;
    logic signed [15:0] speed_out_next;
    logic signed [15:0] current_out_next;

    logic in_ready;
    logic in_fire;

    // feedback path
    logic signed [EB+1:0] fwd_diff;
    logic signed [EB+1:0] back_diff;
    logic signed [17:0]   t_base;
    logic signed [17:0]   t_step;
    logic signed [17:0]   t_fold;
    logic signed [17:0]   t_pre;
    logic signed [17:0]   hr_ext;
    logic signed [17:0]   max_ext;
    logic signed [17:0]   min_ext;
    logic signed [31:0]   rd_ext;
    logic signed [15:0]   t_fb;

    // reset-request path
    logic signed [31:0]   tgt;
    logic signed [32:0]   tgt_bias;
    logic signed [32:0]   tgt_quot;
    logic signed [15:0]   t_rst;
    logic [31:0]          t_rst_counts;
    logic [31:0]          offset_rst;

    logic [31:0]          angle_raw;

    assign in_ready     = !out_valid_reg || out_ch.ready;
    assign in_fire      = in_ch.valid && in_ready;
    assign in_ch.ready  = in_ready;

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.angle_count = angle_count_reg;
    assign out_ch.turn_count  = turn_count_reg;
    assign out_ch.speed_out   = speed_out_reg;
    assign out_ch.current_out = current_out_reg;
    assign out_ch.temp_out    = temp_out_reg;

    // turn counting for a feedback word
    always_comb
    begin
        fwd_diff  = $signed({2'b00, prev_reading_reg}) - $signed({2'b00, in_ch.enc_reading});
        back_diff = $signed({2'b00, in_ch.enc_reading}) - $signed({2'b00, prev_reading_reg});
        t_base    = 18'(turns_reg);
        hr_ext    = $signed({4'b0000, half_ratio_reg});
        max_ext   = 18'(max_turns_reg);
        min_ext   = 18'(min_turns_reg);
        rd_ext    = $signed({{(32-EB){1'b0}}, in_ch.enc_reading});

        if (fwd_diff > $signed((EB+2)'(mte_pkg::HALF_ENC_RANGE)))
        begin
            t_step = t_base + 18'sd1;
        end
        else if (back_diff > $signed((EB+2)'(mte_pkg::HALF_ENC_RANGE)))
        begin
            t_step = t_base - 18'sd1;
        end
        else
        begin
            t_step = t_base;
        end

        // fold around plus or minus half the ratio in absolute format
        t_fold = t_step;
        if (angle_absolute_reg)
        begin
            if ((t_step >= hr_ext) && (rd_ext > $signed(angle_offset_reg)))
            begin
                t_fold = -hr_ext;
            end
            else if ((t_step <= -hr_ext) && (rd_ext < $signed(angle_offset_reg)))
            begin
                t_fold = hr_ext;
            end
        end

        t_pre = (control_mode_reg == mte_pkg::MODE_SPEED) ? 18'sd0 : t_fold;

        if (t_pre > max_ext)
        begin
            t_fb = max_turns_reg;
        end
        else if (t_pre < min_ext)
        begin
            t_fb = min_turns_reg;
        end
        else
        begin
            t_fb = t_pre[15:0];
        end
    end

    // turns and offset from a target in counts
    always_comb
    begin
        if (reversed_reg)
        begin
            tgt = (in_ch.target_count == 32'sh8000_0000) ? 32'sh7fff_ffff
                                                         : -in_ch.target_count;
        end
        else
        begin
            tgt = in_ch.target_count;
        end

        // round toward zero before the arithmetic shift
        tgt_bias = 33'(tgt) + (tgt[31] ? 33'sd0 + 33'(mte_pkg::ENC_RANGE - 1) : 33'sd0);
        tgt_quot = tgt_bias >>> EB;

        if (tgt_quot > 33'sd32767)
        begin
            t_rst = 16'sh7fff;
        end
        else if (tgt_quot < -33'sd32768)
        begin
            t_rst = 16'sh8000;
        end
        else
        begin
            t_rst = tgt_quot[15:0];
        end

        t_rst_counts = 32'(t_rst) << EB;
        offset_rst   = {{(32-EB){1'b0}}, prev_reading_reg} - (32'(tgt) - t_rst_counts);
    end

    // next state and result
    always_comb
    begin
        prev_reading_next = prev_reading_reg;
        turns_next        = turns_reg;
        angle_offset_next = angle_offset_reg;
        last_speed_next   = last_speed_reg;
        last_current_next = last_current_reg;
        last_temp_next    = last_temp_reg;

        if (in_ch.op == mte_pkg::OP_RESET)
        begin
            turns_next        = t_rst;
            angle_offset_next = offset_rst;
        end
        else
        begin
            prev_reading_next = in_ch.enc_reading;
            turns_next        = t_fb;
            last_speed_next   = in_ch.rotor_speed;
            last_current_next = in_ch.motor_current;
            last_temp_next    = in_ch.motor_temp;
            if (control_mode_reg == mte_pkg::MODE_SPEED)
            begin
                angle_offset_next = {{(32-EB){1'b0}}, in_ch.enc_reading};
            end
        end

        angle_raw = (32'(turns_next) << EB) + {{(32-EB){1'b0}}, prev_reading_next}
                    - angle_offset_next;

        if (reversed_reg)
        begin
            angle_count_next = (angle_raw == 32'h8000_0000) ? 32'sh7fff_ffff
                                                            : -$signed(angle_raw);
            speed_out_next   = (last_speed_next == 16'sh8000) ? 16'sh7fff : -last_speed_next;
            current_out_next = (last_current_next == 16'sh8000) ? 16'sh7fff
                                                                : -last_current_next;
        end
        else
        begin
            angle_count_next = $signed(angle_raw);
            speed_out_next   = last_speed_next;
            current_out_next = last_current_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_mode_reg   <= 2'd0;
            angle_absolute_reg <= 1'b0;
            reversed_reg       <= 1'b0;
            max_turns_reg      <= 16'sh7fff;
            min_turns_reg      <= 16'sh8000;
            half_ratio_reg     <= 14'd0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                mte_pkg::REG_CONTROL_MODE:   control_mode_reg   <= cfg_data[1:0];
                mte_pkg::REG_ANGLE_ABSOLUTE: angle_absolute_reg <= cfg_data[0];
                mte_pkg::REG_REVERSED:       reversed_reg       <= cfg_data[0];
                mte_pkg::REG_MAX_TURNS:      max_turns_reg      <= $signed(cfg_data);
                mte_pkg::REG_MIN_TURNS:      min_turns_reg      <= $signed(cfg_data);
                mte_pkg::REG_HALF_RATIO:     half_ratio_reg     <= cfg_data[13:0];
                default:                     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reading_reg <= mte_pkg::RESET_READING;
            turns_reg        <= 16'sd0;
            angle_offset_reg <= 32'd0;
            last_speed_reg   <= 16'sd0;
            last_current_reg <= 16'sd0;
            last_temp_reg    <= 8'd0;
        end
        else if (in_fire)
        begin
            prev_reading_reg <= prev_reading_next;
            turns_reg        <= turns_next;
            angle_offset_reg <= angle_offset_next;
            last_speed_reg   <= last_speed_next;
            last_current_reg <= last_current_next;
            last_temp_reg    <= last_temp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // hold the result word until taken
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            angle_count_reg <= angle_count_next;
            turn_count_reg  <= turns_next;
            speed_out_reg   <= speed_out_next;
            current_out_reg <= current_out_next;
            temp_out_reg    <= last_temp_next;
        end
    end

endmodule

// ===== design/mte_checker.sv =====
module mte_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] angle_count,
    input logic signed [15:0] turn_count
);

    // a stalled result word stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(angle_count) && $stable(turn_count))
        else $error("result word changed while stalled");

    // every accepted word shows a result on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted word produced no result");

    // no new word while the result register is full and stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken over a stalled result");

endmodule

bind multiturn_encoder_tracker mte_checker u_mte_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .angle_count (out_ch.angle_count),
    .turn_count  (out_ch.turn_count)
);
